[src/sfr_pkg.sv]
// shared types and constants for the stream find-and-replace core
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // pattern and replacement limits in bytes
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 4;
    localparam int WIN_W  = PATTERN_MAX * BYTE_W;
    localparam int REP_W  = REPLACE_MAX * BYTE_W;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    // command queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FCNT_W     = 2;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_LEN    = 2'd0,
        REG_TARGET_BYTES  = 2'd1,
        REG_REPLACE_LEN   = 2'd2,
        REG_REPLACE_BYTES = 2'd3
    } sfr_reg_t;

    // one command from the front: head bytes, then flushed tail bytes
    typedef struct packed {
        logic [LEN_W-1:0] head_cnt;
        logic [REP_W-1:0] head_bytes;
        logic [LEN_W-1:0] tail_cnt;
        logic [WIN_W-1:0] tail_bytes;
        logic             last;
    } sfr_cmd_t;

    // queue status seen by the top level
    typedef struct packed {
        logic [FCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } sfr_fifo_stat_t;

endpackage

`default_nettype wire

[src/sfr_front.sv]
// front part: configuration, match window, compare and command build
`timescale 1ns / 1ps
`default_nettype none

module sfr_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write
    input  wire logic                       cfg_valid,
    input  wire logic [sfr_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_W-1:0]  cfg_data,
    // input items
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,
    input  wire logic [0:0]                 s_tuser,
    input  wire logic                       s_tlast,
    // command push
    output logic                            cmd_push,
    output sfr_pkg::sfr_cmd_t               cmd,
    input  wire logic                       cmd_full
);
    import sfr_pkg::*;

    logic [LEN_W-1:0] tl_reg, rl_reg;
    logic [WIN_W-1:0] tgt_reg;
    logic [REP_W-1:0] rep_reg;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;

    logic [LEN_W-1:0] tl_eff, rl_eff;
    logic [WIN_W-1:0] app_bytes, post_bytes, cmp_mask;
    logic [LEN_W-1:0] app_cnt, post_cnt;
    logic             do_cmp, hit, accept;

    assign s_tready = !cmd_full;
    assign accept   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tl_reg  <= LEN_W'(1);
            rl_reg  <= '0;
            tgt_reg <= '0;
            rep_reg <= '0;
        end else if (cfg_valid) begin
            unique case (sfr_reg_t'(cfg_index))
                REG_TARGET_LEN:    tl_reg  <= cfg_data[LEN_W-1:0];
                REG_TARGET_BYTES:  tgt_reg <= cfg_data[WIN_W-1:0];
                REG_REPLACE_LEN:   rl_reg  <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: rep_reg <= cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp lengths to their legal range
    always_comb begin
        if (tl_reg == '0)
            tl_eff = LEN_W'(1);
        else if (tl_reg > LEN_W'(PATTERN_MAX))
            tl_eff = LEN_W'(PATTERN_MAX);
        else
            tl_eff = tl_reg;
        rl_eff = (rl_reg > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rl_reg;
    end

    // append, compare once, build command and next window
    always_comb begin
        app_bytes = win_reg;
        app_cnt   = cnt_reg;
        if (s_tuser[0] && (cnt_reg < LEN_W'(PATTERN_MAX))) begin
            app_bytes = win_reg | ({{(WIN_W-BYTE_W){1'b0}}, s_tdata} << {cnt_reg[2:0], 3'b000});
            app_cnt   = cnt_reg + LEN_W'(1);
        end

        do_cmp   = s_tuser[0] && (app_cnt >= tl_eff);
        cmp_mask = ~({WIN_W{1'b1}} << {tl_eff, 3'b000});
        hit      = (((app_bytes ^ tgt_reg) & cmp_mask) == '0);

        cmd        = '0;
        post_bytes = app_bytes;
        post_cnt   = app_cnt;
        if (do_cmp) begin
            if (hit) begin
                cmd.head_bytes = rep_reg;
                cmd.head_cnt   = rl_eff;
                post_bytes     = app_bytes >> {tl_eff, 3'b000};
                post_cnt       = app_cnt - tl_eff;
            end else begin
                cmd.head_bytes = {{(REP_W-BYTE_W){1'b0}}, app_bytes[BYTE_W-1:0]};
                cmd.head_cnt   = LEN_W'(1);
                post_bytes     = app_bytes >> BYTE_W;
                post_cnt       = app_cnt - LEN_W'(1);
            end
        end

        // last item flushes what is left
        win_next = post_bytes;
        cnt_next = post_cnt;
        cmd.last = s_tlast;
        if (s_tlast) begin
            cmd.tail_bytes = post_bytes;
            cmd.tail_cnt   = post_cnt;
            win_next       = '0;
            cnt_next       = '0;
        end

        cmd_push = accept && (s_tlast || (do_cmp && (cmd.head_cnt != '0)));
    end

    // window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            win_reg <= win_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[src/sfr_cmd_fifo.sv]
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module sfr_cmd_fifo (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire sfr_pkg::sfr_cmd_t       push_cmd,
    input  wire logic                    pop,
    output sfr_pkg::sfr_cmd_t            head_cmd,
    output sfr_pkg::sfr_fifo_stat_t      stat
);
    import sfr_pkg::*;

    sfr_cmd_t          mem_reg [FIFO_DEPTH];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign stat.count = cnt_reg;
    assign stat.full  = (cnt_reg == FCNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + FCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - FCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

[src/sfr_back.sv]
// back part: walks one command and drives the output register
`timescale 1ns / 1ps
`default_nettype none

module sfr_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cmd_valid,
    input  wire sfr_pkg::sfr_cmd_t  cmd,
    output logic                    cmd_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic [0:0]              m_tuser,
    output logic                    m_tlast
);
    import sfr_pkg::*;

    logic [LEN_W-1:0]  idx_reg;
    logic              vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              flag_reg, last_reg;

    logic [LEN_W:0]    total;
    logic [LEN_W-1:0]  tail_idx;
    logic [BYTE_W-1:0] sel_byte;
    logic              is_final, load;

    assign m_tvalid = vld_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = flag_reg;
    assign m_tlast  = last_reg;

    // pick the byte at the current position
    always_comb begin
        total    = {1'b0, cmd.head_cnt} + {1'b0, cmd.tail_cnt};
        tail_idx = idx_reg - cmd.head_cnt;
        if (total == '0)
            sel_byte = '0;
        else if (idx_reg < cmd.head_cnt)
            sel_byte = cmd.head_bytes[{idx_reg[2:0], 3'b000} +: BYTE_W];
        else
            sel_byte = cmd.tail_bytes[{tail_idx[2:0], 3'b000} +: BYTE_W];
        is_final = (({1'b0, idx_reg} + (LEN_W+1)'(1)) >= total);
        load     = cmd_valid && (!vld_reg || m_tready);
        cmd_pop  = load && is_final;
    end

    // output register and position counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (load) begin
                vld_reg <= 1'b1;
                idx_reg <= is_final ? '0 : idx_reg + LEN_W'(1);
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            flag_reg <= (total != '0);
            last_reg <= cmd.last && is_final;
        end
    end

endmodule

`default_nettype wire

[src/stream_find_and_replace_core.sv]
// top level of the stream find-and-replace core
`timescale 1ns / 1ps
`default_nettype none

// Replaces every leftmost, non-overlapping occurrence of a 1..8 byte pattern
// in a byte stream with a 0..8 byte replacement. The front accepts one item
// per cycle whenever the two-entry command queue has room: it appends the
// byte to an eight-byte window, makes one parallel compare and queues the
// bytes that the item releases. The back drains each command through the
// output register at one result per cycle while the receiver is ready; when
// replacements expand the text, the sustained rate is set by the output
// port at one result per cycle. A run that ends with no bytes gives one
// result with tuser low and tlast high. The configuration port is always
// ready; the user must write it between runs, the block does not enforce it.
module stream_find_and_replace_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [sfr_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [sfr_pkg::CFG_W-1:0]  cfg_data,
    // input stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]                 s_tuser,   // [0] in_valid
    input  wire logic                       s_tlast,
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic [0:0]                      m_tuser,   // [0] out_valid
    output logic                            m_tlast
);
    import sfr_pkg::*;

    sfr_cmd_t       push_cmd, head_cmd;
    sfr_fifo_stat_t fifo_stat;
    logic           cmd_push, cmd_pop;

    assign cfg_ready = 1'b1;

    // classify and compare
    sfr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd_push (cmd_push),
        .cmd      (push_cmd),
        .cmd_full (fifo_stat.full)
    );

    // command queue
    sfr_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .push_cmd(push_cmd),
        .pop     (cmd_pop),
        .head_cmd(head_cmd),
        .stat    (fifo_stat)
    );

    // result serializer
    sfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(!fifo_stat.empty),
        .cmd      (head_cmd),
        .cmd_pop  (cmd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // a bare end marker always closes the run
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("end marker without tlast");

    // a bare end marker carries a zero byte
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("end marker with nonzero byte");

    // queue never overfills
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.count <= FCNT_W'(FIFO_DEPTH))
        else $error("command queue overflow");

    // a push into a full queue is never issued
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> !fifo_stat.full)
        else $error("push while queue full");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for the stream find-and-replace core: directed table, then random strings
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 40;     // command queue plus output register, with margin
    localparam int HOLD_CYCLES   = 100;    // long receiver hold-off
    localparam int RANDOM_ITEMS  = 210;
    localparam int CALM_ITEMS    = 50;     // final stretch without idling
    localparam int CYCLE_LIMIT   = 400000;

    // one result item: byte, byte-present flag, end of string
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_item_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t   kind;
        sfr_reg_t    idx;
        logic [63:0] data;
        logic [7:0]  b;
        logic        v;
        logic        l;
        bit          typed;
        out_item_t   want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    sfr_reg_t    cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    stream_find_and_replace_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // predictor copy of the registers and the pending window
    logic [3:0]  pat_len_reg   = 4'd1;
    logic [63:0] pat_bytes_reg = '0;
    logic [3:0]  rep_len_reg   = 4'd0;
    logic [63:0] rep_bytes_reg = '0;
    logic [7:0]  win_bytes [PATTERN_MAX] = '{default: 8'h00};
    int          win_fill = 0;

    out_item_t   replaced_q[$];        // results still owed by the block
    bit          typed_on = 1'b0;      // directed row carries its own result
    out_item_t   typed_want = '0;

    int errors = 0;
    int cycles = 0;
    int items_in = 0;
    int strings_done = 0;
    int results_checked = 0;
    int pattern_hits = 0;
    int reg_writes = 0;

    // stimulus control
    bit          gap_en = 1'b0;
    bit          stall_en = 1'b0;
    bit          hold_req = 1'b0;
    int          rand_items = 0;
    int          ph_tl = 1;
    logic [63:0] ph_pat = '0;
    logic [7:0]  alpha [3];

    row_t dir_rows[$];

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_checked, got, want);
    endtask

    function automatic void shift_window(input int k);
        int i;
        for (i = 0; i < PATTERN_MAX; i++) begin
            win_bytes[i] = (i + k < win_fill) ? win_bytes[i + k] : 8'h00;
        end
        win_fill -= k;
    endfunction

    // one compare per item, then flush on the last item
    task automatic replace_step(input logic [7:0] b, input logic v, input logic l);
        out_item_t outs[$];
        out_item_t tmp;
        int        tl;
        int        rl;
        int        k;
        bit        hit;
        tl = (pat_len_reg == 4'd0) ? 1 :
             (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
        rl = (rep_len_reg > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len_reg);
        if (v) begin
            if (win_fill < PATTERN_MAX) begin
                win_bytes[win_fill] = b;
                win_fill++;
            end
            if (win_fill >= tl) begin
                hit = 1'b1;
                for (k = 0; k < tl; k++) begin
                    if (win_bytes[k] != pat_bytes_reg[8*k +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (k = 0; k < rl; k++) begin
                        tmp = '{rep_bytes_reg[8*k +: 8], 1'b1, 1'b0};
                        outs.push_back(tmp);
                    end
                    shift_window(tl);
                    pattern_hits++;
                end else begin
                    tmp = '{win_bytes[0], 1'b1, 1'b0};
                    outs.push_back(tmp);
                    shift_window(1);
                end
            end
        end
        if (l) begin
            for (k = 0; k < win_fill; k++) begin
                tmp = '{win_bytes[k], 1'b1, 1'b0};
                outs.push_back(tmp);
            end
            shift_window(win_fill);
            // a string that ends with no bytes still closes with a bare marker
            if (outs.size() == 0) begin
                tmp = '{8'h00, 1'b0, 1'b1};
            end else begin
                tmp = outs.pop_back();
                tmp.last = 1'b1;
            end
            outs.push_back(tmp);
            strings_done++;
        end
        if (typed_on) begin
            replaced_q.push_back(typed_want);
        end else begin
            foreach (outs[i]) replaced_q.push_back(outs[i]);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_checked++;
        if (replaced_q.size() == 0) begin
            report_mismatch("result with nothing expected", got, 0);
        end else begin
            want = replaced_q.pop_front();
            if (got.data !== want.data) report_mismatch("out_byte", got.data, want.data);
            if (got.valid !== want.valid) report_mismatch("out_valid", got.valid, want.valid);
            if (got.last !== want.last) report_mismatch("out_last", got.last, want.last);
        end
    endtask

    // sample all handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result('{m_tdata, m_tuser[0], m_tlast});
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    REG_TARGET_LEN:    pat_len_reg = cfg_data[3:0];
                    REG_TARGET_BYTES:  pat_bytes_reg = cfg_data;
                    REG_REPLACE_LEN:   rep_len_reg = cfg_data[3:0];
                    REG_REPLACE_BYTES: rep_bytes_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                items_in++;
                replace_step(s_tdata, s_tuser[0], s_tlast);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one item, with an optional gap first, and wait for acceptance
    task automatic send_item(input logic [7:0] b, input logic v, input logic l,
                             input bit typed, input out_item_t want);
        @(negedge aclk);
        if (gap_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser    <= v;
        s_tlast    <= l;
        typed_on   = typed;
        typed_want = want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every owed result arrive
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replaced_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_put(input sfr_reg_t idx, input logic [63:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_regs(input logic [3:0] tl, input logic [63:0] tp,
                              input logic [3:0] rl, input logic [63:0] rp);
        wait_drained();
        cfg_put(REG_TARGET_LEN, {60'd0, tl});
        cfg_put(REG_TARGET_BYTES, tp);
        cfg_put(REG_REPLACE_LEN, {60'd0, rl});
        cfg_put(REG_REPLACE_BYTES, rp);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly pattern copies and alphabet bytes, some noise and no-byte items, sometimes a bare end
    task automatic send_string(input int n_bytes, input bit pause_mid);
        logic [7:0] seq[$];
        int         k;
        bit         end_bare;
        while (seq.size() < n_bytes) begin
            if ($urandom_range(0, 2) == 0) begin
                for (k = 0; k < ph_tl; k++) seq.push_back(ph_pat[8*k +: 8]);
            end else if ($urandom_range(0, 3) != 0) begin
                seq.push_back(alpha[$urandom_range(0, 2)]);
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        end_bare = (seq.size() == 0) || ($urandom_range(0, 4) == 0);
        for (k = 0; k < seq.size(); k++) begin
            if (pause_mid && k == seq.size() / 2) wait_drained();
            if ($urandom_range(0, 19) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            end
            send_item(seq[k], 1'b1, !end_bare && k == seq.size() - 1, 1'b0, '0);
            rand_items++;
        end
        if (end_bare) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            rand_items++;
        end
    endtask

    function automatic row_t item_row(input logic [7:0] b, input logic v, input logic l);
        row_t r;
        r = '{ROW_ITEM, REG_TARGET_LEN, 64'd0, b, v, l, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t chk_row(input logic [7:0] b, input logic v, input logic l,
                                     input logic [7:0] eb, input logic ev, input logic el);
        row_t r;
        r = '{ROW_ITEM, REG_TARGET_LEN, 64'd0, b, v, l, 1'b1, '{eb, ev, el}};
        return r;
    endfunction

    function automatic row_t cfg_row(input sfr_reg_t idx, input logic [63:0] d);
        row_t r;
        r = '{ROW_CFG, idx, d, 8'h00, 1'b0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    // main stimulus
    initial begin
        logic [3:0]  tl_code;
        logic [3:0]  rl_code;
        logic [63:0] pat;
        int          n_phase;
        int          budget;
        int          start;
        int          r;
        int          k;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET_LEN;
        cfg_data  = '0;

        // directed table, starting from the reset settings (one byte 00, delete)
        dir_rows.push_back(chk_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1)); // empty string
        dir_rows.push_back(chk_row(8'h41, 1'b1, 1'b1, 8'h41, 1'b1, 1'b1));
        dir_rows.push_back(chk_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1)); // zero byte deleted
        dir_rows.push_back(chk_row(8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1));
        // three-byte pattern expanded to eight bytes
        dir_rows.push_back(cfg_row(REG_TARGET_LEN, 64'd3));
        dir_rows.push_back(cfg_row(REG_TARGET_BYTES, 64'h0000_0000_0063_6261));
        dir_rows.push_back(cfg_row(REG_REPLACE_LEN, 64'd8));
        dir_rows.push_back(cfg_row(REG_REPLACE_BYTES, 64'hFF00_8001_7F55_AA01));
        dir_rows.push_back(item_row(8'h78, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h61, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h62, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h63, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h79, 1'b1, 1'b1));
        // zero target length acts as one, oversized replace length saturates
        dir_rows.push_back(cfg_row(REG_TARGET_LEN, 64'd0));
        dir_rows.push_back(cfg_row(REG_TARGET_BYTES, 64'hFFFF_FFFF_FFFF_FF41));
        dir_rows.push_back(cfg_row(REG_REPLACE_LEN, 64'd15));
        dir_rows.push_back(cfg_row(REG_REPLACE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(item_row(8'h41, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h42, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b0, 1'b0));                  // no byte, not last
        dir_rows.push_back(item_row(8'h41, 1'b1, 1'b1));
        // oversized target length saturates to eight, match deleted
        dir_rows.push_back(cfg_row(REG_TARGET_LEN, 64'd15));
        dir_rows.push_back(cfg_row(REG_TARGET_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_REPLACE_LEN, 64'd0));
        for (k = 0; k < 8; k++) dir_rows.push_back(item_row(8'hFF, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h01, 1'b1, 1'b1));
        // settings changed inside a string, then a bare last item flushes
        dir_rows.push_back(cfg_row(REG_TARGET_LEN, 64'd4));
        dir_rows.push_back(cfg_row(REG_TARGET_BYTES, 64'h0000_0000_4443_4241));
        dir_rows.push_back(item_row(8'h41, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h42, 1'b1, 1'b0));
        dir_rows.push_back(cfg_row(REG_TARGET_LEN, 64'd1));
        dir_rows.push_back(cfg_row(REG_REPLACE_LEN, 64'd2));
        dir_rows.push_back(cfg_row(REG_REPLACE_BYTES, 64'h0000_0000_0000_7F80));
        dir_rows.push_back(item_row(8'h43, 1'b1, 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b0, 1'b1));

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        gap_en   = 1'b1;
        stall_en = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drained();
                cfg_put(dir_rows[i].idx, dir_rows[i].data);
                @(negedge aclk);
                cfg_valid <= 1'b0;
            end else begin
                send_item(dir_rows[i].b, dir_rows[i].v, dir_rows[i].l,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random phases, each under fresh settings
        n_phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items >= RANDOM_ITEMS - CALM_ITEMS) begin
                gap_en   = 1'b0;
                stall_en = 1'b0;
            end else begin
                gap_en   = $urandom_range(0, 3) != 0;
                stall_en = $urandom_range(0, 3) != 0;
            end
            case (n_phase)
                0: begin
                    tl_code = 4'd8;
                    rl_code = 4'd8;
                end
                1: begin
                    tl_code = 4'd1;
                    rl_code = 4'd0;
                end
                default: begin
                    r = $urandom_range(0, 7);
                    tl_code = (r == 0) ? 4'd0 :
                              (r == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
                    rl_code = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) :
                                                             4'($urandom_range(0, 8));
                end
            endcase
            for (k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) alpha[2] = 8'h00;
            for (k = 0; k < 8; k++) pat[8*k +: 8] = alpha[$urandom_range(0, 2)];
            ph_pat = pat;
            ph_tl  = (tl_code == 4'd0) ? 1 : (tl_code > 4'd8) ? 8 : int'(tl_code);
            write_regs(tl_code, pat, rl_code, {$urandom, $urandom});

            // first phase: the receiver holds off while items keep coming
            if (n_phase == 0) begin
                @(posedge aclk);
                hold_req = 1'b1;
            end

            budget = $urandom_range(12, 30);
            start  = rand_items;
            send_string(12, n_phase == 1);
            while (rand_items - start < budget) send_string($urandom_range(0, 12), 1'b0);
            n_phase++;
        end

        wait_drained();
        if (replaced_q.size() != 0) report_mismatch("results never delivered", replaced_q.size(), 0);

        $display("covered %0d items in %0d strings with %0d register writes over %0d phases",
                 items_in, strings_done, reg_writes, n_phase);
        $display("checked %0d results, %0d pattern hits, %0d mismatches",
                 results_checked, pattern_hits, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/sfr_pkg.sv
src/sfr_front.sv
src/sfr_cmd_fifo.sv
src/sfr_back.sv
src/stream_find_and_replace_core.sv
tb/tb.sv
